// ----- sv/directional_line_start_generator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Directional line start generator assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_LINE_START_GENERATOR_UNIT_MACROS_SVH
`define DIRECTIONAL_LINE_START_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define DLSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dlsg_pkg.sv -----
// ----------------------------------------------------------------------------
// Directional line start generator package
// Widths, register indexes, state types and divider interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dlsg_pkg;

  localparam int COORD_BITS    = 16;
  localparam int EXT_BITS      = COORD_BITS + 2;
  localparam int STEP_BITS     = 5;
  localparam int DEN_BITS      = STEP_BITS - 1;
  localparam int STEP_MAX      = 15;
  localparam int NUM_BITS      = COORD_BITS;
  localparam int ITER_BITS     = $clog2(NUM_BITS);
  localparam int CFG_ADDR_BITS = 3;
  localparam int IN_TDATA_BITS = 8;
  localparam int OUT_TDATA_BITS = 3 * COORD_BITS;

  localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_LEFT   = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_RIGHT  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_TOP    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_BOTTOM = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_X     = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_Y     = 3'd5;

  localparam logic signed [EXT_BITS-1:0] ONE_E = EXT_BITS'(1);

  typedef enum logic [1:0] {
    PH_DONE,
    PH_TOP,
    PH_SIDE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV1,
    ST_DIV2,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic                start;
    logic [NUM_BITS-1:0] numer;
    logic [DEN_BITS-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NUM_BITS-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/dlsg_div.sv -----
// ----------------------------------------------------------------------------
// Directional line start generator divider
// Restoring unsigned divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsg_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dlsg_pkg::div_req_t req,
  output dlsg_pkg::div_rsp_t      rsp
);

  logic                                busy_r;
  logic                                done_r;
  logic [dlsg_pkg::ITER_BITS-1:0]      cnt_r;
  logic [dlsg_pkg::DEN_BITS-1:0]       rem_r;
  logic [dlsg_pkg::NUM_BITS-1:0]       quo_r;
  logic [dlsg_pkg::DEN_BITS-1:0]       den_r;
  logic [dlsg_pkg::DEN_BITS:0]         trial;
  logic [dlsg_pkg::DEN_BITS:0]         diff;
  logic                                ge;

  assign trial = {rem_r, quo_r[dlsg_pkg::NUM_BITS-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == dlsg_pkg::ITER_BITS'(dlsg_pkg::NUM_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.numer;
      den_r <= req.denom;
    end else if (busy_r) begin
      rem_r <= ge ? diff[dlsg_pkg::DEN_BITS-1:0] : trial[dlsg_pkg::DEN_BITS-1:0];
      quo_r <= {quo_r[dlsg_pkg::NUM_BITS-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

`default_nettype wire

// ----- sv/directional_line_start_generator_unit.sv -----
// Items are handled one at a time: an exhausted walk goes straight to the
//   result, a line takes one or two per-axis counts, each one pass of the
//   shared restoring divider, and the next item is taken on return to idle,
//   once the result has moved into the output register.
// Reset (rst_n low, synchronous): walk finished, registers to their reset
//   values (step_x 1, all others 0), output channel empty.
// ----------------------------------------------------------------------------
// Directional line start generator
// Gives one output per item: a border line's start pixel and in-box pixel count, or an all-zero item once exhausted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "directional_line_start_generator_unit_macros.svh"

module directional_line_start_generator_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [dlsg_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  wire logic [dlsg_pkg::COORD_BITS-1:0]       cfg_wdata,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // [0] restart, [7:1] zero
  input  wire logic [dlsg_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [15:0] start_x, [31:16] start_y, [47:32] line_length
  output logic [dlsg_pkg::OUT_TDATA_BITS-1:0]        out_tdata,
  // [0] line_valid
  output logic                                       out_tuser,
  output logic                                       out_tlast
);

  localparam int CB = dlsg_pkg::COORD_BITS;
  localparam int EB = dlsg_pkg::EXT_BITS;
  localparam int SB = dlsg_pkg::STEP_BITS;
  localparam int DB = dlsg_pkg::DEN_BITS;
  localparam int NB = dlsg_pkg::NUM_BITS;

  function automatic logic signed [EB-1:0] ext_s(input logic [CB-1:0] v);
    return EB'($signed(v));
  endfunction

  function automatic logic signed [EB-1:0] ext_u(input logic [DB:0] v);
    return $signed(EB'(v));
  endfunction

  // configuration registers
  logic [CB-1:0] box_left_r, box_right_r, box_top_r, box_bottom_r;
  logic [SB-1:0] step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r   <= '0;
      box_right_r  <= '0;
      box_top_r    <= '0;
      box_bottom_r <= '0;
      step_x_r     <= SB'(1);
      step_y_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        dlsg_pkg::REG_BOX_LEFT:   box_left_r   <= cfg_wdata;
        dlsg_pkg::REG_BOX_RIGHT:  box_right_r  <= cfg_wdata;
        dlsg_pkg::REG_BOX_TOP:    box_top_r    <= cfg_wdata;
        dlsg_pkg::REG_BOX_BOTTOM: box_bottom_r <= cfg_wdata;
        dlsg_pkg::REG_STEP_X:     step_x_r     <= cfg_wdata[SB-1:0];
        dlsg_pkg::REG_STEP_Y:     step_y_r     <= cfg_wdata[SB-1:0];
        default: ;
      endcase
    end
  end

  // walk state
  dlsg_pkg::seq_state_t      state_r, state_nxt;
  dlsg_pkg::phase_t          phase_r, phase_nxt;
  logic [DB-1:0]             border_r, border_nxt;
  logic signed [EB-1:0]      cx_r, cx_nxt, cy_r, cy_nxt, side_top_r, side_top_nxt;
  logic [CB-1:0]             wl_r, wl_nxt, wr_r, wr_nxt, wt_r, wt_nxt, wb_r, wb_nxt;
  logic signed [SB-1:0]      dx_r, dx_nxt;
  logic [DB-1:0]             dy_r, dy_nxt;
  logic                      live_r, live_nxt;
  logic                      empty_r, empty_nxt;
  logic [NB-1:0]             c1_r, c1_nxt, len_r, len_nxt;

  // output register
  logic                      ov_r, ov_nxt;
  logic [CB-1:0]             ox_r, ox_nxt, oy_r, oy_nxt, olen_r, olen_nxt;
  logic                      oline_r, oline_nxt, olast_r, olast_nxt;

  dlsg_pkg::div_req_t        div_req;
  dlsg_pkg::div_rsp_t        div_rsp;

  dlsg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // restart values from the configuration
  logic signed [SB-1:0] sx_c, sy_c, rdx;
  logic [DB-1:0]        rdy;
  logic signed [EB-1:0] cl, cr, ct, cb;
  logic                 r_empty;

  always_comb begin
    sx_c = $signed(step_x_r);
    sy_c = $signed(step_y_r);
    if (sx_c < -dlsg_pkg::STEP_MAX) sx_c = SB'(-dlsg_pkg::STEP_MAX);
    if (sx_c > dlsg_pkg::STEP_MAX)  sx_c = SB'(dlsg_pkg::STEP_MAX);
    if (sy_c < -dlsg_pkg::STEP_MAX) sy_c = SB'(-dlsg_pkg::STEP_MAX);
    if (sy_c > dlsg_pkg::STEP_MAX)  sy_c = SB'(dlsg_pkg::STEP_MAX);
    if (sy_c < 0) begin
      rdx = -sx_c;
      rdy = DB'(-sy_c);
    end else begin
      rdx = sx_c;
      rdy = DB'(sy_c);
    end
    cl = ext_s(box_left_r);
    cr = ext_s(box_right_r);
    ct = ext_s(box_top_r);
    cb = ext_s(box_bottom_r);
    r_empty = (cr <= cl) || (cb <= ct) || ((rdx == '0) && (rdy == '0));
  end

  // walk views
  logic signed [EB-1:0] el, er, et, eb;
  logic                 dx_pos;
  logic [DB-1:0]        adx;

  assign el     = ext_s(wl_r);
  assign er     = ext_s(wr_r);
  assign et     = ext_s(wt_r);
  assign eb     = ext_s(wb_r);
  assign dx_pos = dx_r > 0;
  assign adx    = dx_r < 0 ? DB'(-dx_r) : DB'(dx_r);

  // advance to the next line
  dlsg_pkg::phase_t     adv_phase;
  logic [DB-1:0]        adv_border;
  logic signed [EB-1:0] adv_cx, adv_cy, adv_side;
  logic [DB:0]          nbi;
  logic signed [EB-1:0] side_start, side_cx;

  always_comb begin
    adv_phase  = phase_r;
    adv_border = border_r;
    adv_cx     = cx_r;
    adv_cy     = cy_r;
    adv_side   = side_top_r;
    nbi        = {1'b0, border_r} + 1'b1;
    side_start = et + ext_u({1'b0, dy_r});
    side_cx    = dx_pos ? el : er - dlsg_pkg::ONE_E;
    case (phase_r)
      dlsg_pkg::PH_TOP: begin
        if (cx_r + dlsg_pkg::ONE_E >= er) begin
          adv_cx = el;
          if (nbi >= {1'b0, dy_r}) begin
            if (dx_r == '0 || side_start >= eb) begin
              adv_phase = dlsg_pkg::PH_DONE;
            end else begin
              adv_phase  = dlsg_pkg::PH_SIDE;
              adv_border = '0;
              adv_cy     = side_start;
              adv_cx     = side_cx;
              adv_side   = side_start;
            end
          end else begin
            adv_border = nbi[DB-1:0];
            adv_cy     = et + ext_u(nbi);
          end
        end else begin
          adv_cx = cx_r + dlsg_pkg::ONE_E;
        end
      end
      dlsg_pkg::PH_SIDE: begin
        if (cy_r + dlsg_pkg::ONE_E >= eb) begin
          adv_cy = side_top_r;
          if (nbi >= {1'b0, adx}) begin
            adv_phase = dlsg_pkg::PH_DONE;
          end else begin
            adv_border = nbi[DB-1:0];
            adv_cx     = dx_pos ? el + ext_u(nbi) : er - dlsg_pkg::ONE_E - ext_u(nbi);
          end
        end else begin
          adv_cy = cy_r + dlsg_pkg::ONE_E;
        end
      end
      default: ;
    endcase
  end

  // per-axis count operands
  logic signed [EB-1:0] s1, e1, s2, e2, n1, n2;
  logic [DB-1:0]        d1, d2;
  logic                 need2;

  always_comb begin
    if (phase_r == dlsg_pkg::PH_SIDE) begin
      s1    = el + ext_u({1'b0, border_r});
      e1    = er;
      d1    = adx;
      s2    = cy_r;
      e2    = eb;
      d2    = dy_r;
      need2 = dy_r != '0;
    end else begin
      s1    = et + ext_u({1'b0, border_r});
      e1    = eb;
      d1    = dy_r;
      s2    = dx_pos ? cx_r : el;
      e2    = dx_pos ? er : cx_r + dlsg_pkg::ONE_E;
      d2    = adx;
      need2 = dx_r != '0;
    end
    n1 = e1 - s1 - dlsg_pkg::ONE_E;
    n2 = e2 - s2 - dlsg_pkg::ONE_E;
  end

  logic [NB-1:0] cnt_res;
  logic          out_free;

  assign cnt_res  = empty_r ? '0 : div_rsp.quot + NB'(1);
  assign out_free = !ov_r || out_tready;
  assign in_tready = state_r == dlsg_pkg::ST_IDLE;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    border_nxt   = border_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    side_top_nxt = side_top_r;
    wl_nxt       = wl_r;
    wr_nxt       = wr_r;
    wt_nxt       = wt_r;
    wb_nxt       = wb_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    live_nxt     = live_r;
    empty_nxt    = empty_r;
    c1_nxt       = c1_r;
    len_nxt      = len_r;
    ov_nxt       = ov_r && !out_tready;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    olen_nxt     = olen_r;
    oline_nxt    = oline_r;
    olast_nxt    = olast_r;
    div_req      = '0;
    case (state_r)
      dlsg_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = dlsg_pkg::ST_PREP;
          if (in_tdata[0]) begin
            wl_nxt     = box_left_r;
            wr_nxt     = box_right_r;
            wt_nxt     = box_top_r;
            wb_nxt     = box_bottom_r;
            dx_nxt     = rdx;
            dy_nxt     = rdy;
            border_nxt = '0;
            if (r_empty) begin
              phase_nxt = dlsg_pkg::PH_DONE;
            end else if (rdy != '0) begin
              phase_nxt = dlsg_pkg::PH_TOP;
              cx_nxt    = cl;
              cy_nxt    = ct;
            end else begin
              phase_nxt    = dlsg_pkg::PH_SIDE;
              side_top_nxt = ct;
              cy_nxt       = ct;
              cx_nxt       = rdx > 0 ? cl : cr - dlsg_pkg::ONE_E;
            end
          end
        end
      end
      dlsg_pkg::ST_PREP: begin
        if (phase_r == dlsg_pkg::PH_DONE) begin
          live_nxt  = 1'b0;
          state_nxt = dlsg_pkg::ST_FIN;
        end else begin
          live_nxt      = 1'b1;
          empty_nxt     = s1 >= e1;
          div_req.start = 1'b1;
          div_req.numer = n1[NB-1:0];
          div_req.denom = d1;
          state_nxt     = dlsg_pkg::ST_DIV1;
        end
      end
      dlsg_pkg::ST_DIV1: begin
        if (div_rsp.done) begin
          if (need2) begin
            c1_nxt        = cnt_res;
            empty_nxt     = s2 >= e2;
            div_req.start = 1'b1;
            div_req.numer = n2[NB-1:0];
            div_req.denom = d2;
            state_nxt     = dlsg_pkg::ST_DIV2;
          end else begin
            len_nxt   = cnt_res;
            state_nxt = dlsg_pkg::ST_FIN;
          end
        end
      end
      dlsg_pkg::ST_DIV2: begin
        if (div_rsp.done) begin
          len_nxt   = c1_r < cnt_res ? c1_r : cnt_res;
          state_nxt = dlsg_pkg::ST_FIN;
        end
      end
      dlsg_pkg::ST_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          state_nxt = dlsg_pkg::ST_IDLE;
          if (live_r) begin
            ox_nxt       = cx_r[CB-1:0];
            oy_nxt       = cy_r[CB-1:0];
            olen_nxt     = len_r;
            oline_nxt    = 1'b1;
            olast_nxt    = adv_phase == dlsg_pkg::PH_DONE;
            phase_nxt    = adv_phase;
            border_nxt   = adv_border;
            cx_nxt       = adv_cx;
            cy_nxt       = adv_cy;
            side_top_nxt = adv_side;
          end else begin
            ox_nxt    = '0;
            oy_nxt    = '0;
            olen_nxt  = '0;
            oline_nxt = 1'b0;
            olast_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = dlsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dlsg_pkg::ST_IDLE;
      phase_r    <= dlsg_pkg::PH_DONE;
      border_r   <= '0;
      cx_r       <= '0;
      cy_r       <= '0;
      side_top_r <= '0;
      wl_r       <= '0;
      wr_r       <= '0;
      wt_r       <= '0;
      wb_r       <= '0;
      dx_r       <= SB'(1);
      dy_r       <= '0;
      live_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      border_r   <= border_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      side_top_r <= side_top_nxt;
      wl_r       <= wl_nxt;
      wr_r       <= wr_nxt;
      wt_r       <= wt_nxt;
      wb_r       <= wb_nxt;
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      live_r     <= live_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    empty_r <= empty_nxt;
    c1_r    <= c1_nxt;
    len_r   <= len_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    olen_r  <= olen_nxt;
    oline_r <= oline_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {olen_r, oy_r, ox_r};
  assign out_tuser  = oline_r;
  assign out_tlast  = olast_r;

  `DLSG_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accept")
  `DLSG_ASSERT_IMP(a_done_zero, out_tvalid && !out_tuser, out_tdata == '0 && !out_tlast, "exhausted item not zero")
  `DLSG_ASSERT_IMP(a_last_valid, out_tvalid && out_tlast, out_tuser, "last line without line")
  `DLSG_ASSERT_IMP(a_div_state, div_rsp.done, state_r == dlsg_pkg::ST_DIV1 || state_r == dlsg_pkg::ST_DIV2, "divider done outside count")
  `DLSG_ASSERT_IMP(a_fin_phase, state_r == dlsg_pkg::ST_FIN && live_r, phase_r != dlsg_pkg::PH_DONE, "live line in finished walk")

endmodule

`default_nettype wire

// ----- dv/line_start_checker.sv -----
// ----------------------------------------------------------------------------
// Line start checker
// Watches the register port and both stream channels, keeps its own copy of
// the border walk, and compares every emitted line with the predicted one.
// ----------------------------------------------------------------------------
module line_start_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dlsg_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [dlsg_pkg::COORD_BITS-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  // [0] restart, [7:1] zero
  input  logic [dlsg_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] start_x, [31:16] start_y, [47:32] line_length
  input  logic [dlsg_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  // [0] line_valid
  input  logic                                 out_tuser,
  input  logic                                 out_tlast,
  output int                                   fail_count,
  output int                                   lines_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = dlsg_pkg::COORD_BITS;
  localparam int SB = dlsg_pkg::STEP_BITS;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] len;
    logic          valid;
    logic          last;
  } line_t;

  logic [CB-1:0] reg_left, reg_right, reg_top, reg_bottom;
  logic [SB-1:0] reg_step_x, reg_step_y;

  // walk copy, latched at restart
  longint box_l, box_r, box_t, box_b, dir_x, dir_y;
  dlsg_pkg::phase_t walk_phase;
  longint walk_k, pos_x, pos_y, col_top;

  line_t  line_q[$];

  function automatic longint span(longint s, longint e, longint d);
    if (s >= e || d <= 0) return 0;
    return (e - s - 1) / d + 1;
  endfunction

  function automatic longint step_clip(logic [SB-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > dlsg_pkg::STEP_MAX) return dlsg_pkg::STEP_MAX;
    if (v < -dlsg_pkg::STEP_MAX) return -dlsg_pkg::STEP_MAX;
    return v;
  endfunction

  task automatic begin_columns();
    if (dir_x == 0) begin
      walk_phase = dlsg_pkg::PH_DONE;
      return;
    end
    col_top = box_t + dir_y;
    if (col_top >= box_b) begin
      walk_phase = dlsg_pkg::PH_DONE;
      return;
    end
    walk_phase = dlsg_pkg::PH_SIDE;
    walk_k = 0;
    pos_y = col_top;
    pos_x = (dir_x > 0) ? box_l : box_r - 1;
  endtask

  task automatic restart_walk();
    longint sx, sy;
    sx = step_clip(reg_step_x);
    sy = step_clip(reg_step_y);
    if (sy < 0) begin
      sx = -sx;
      sy = -sy;
    end
    box_l = longint'($signed(reg_left));
    box_r = longint'($signed(reg_right));
    box_t = longint'($signed(reg_top));
    box_b = longint'($signed(reg_bottom));
    dir_x = sx;
    dir_y = sy;
    walk_phase = dlsg_pkg::PH_DONE;
    walk_k = 0;
    if (box_r <= box_l || box_b <= box_t || (dir_x == 0 && dir_y == 0)) return;
    if (dir_y != 0) begin
      walk_phase = dlsg_pkg::PH_TOP;
      pos_x = box_l;
      pos_y = box_t;
    end else begin
      begin_columns();
    end
  endtask

  task automatic move_on();
    longint ax;
    ax = (dir_x < 0) ? -dir_x : dir_x;
    if (walk_phase == dlsg_pkg::PH_TOP) begin
      pos_x++;
      if (pos_x >= box_r) begin
        pos_x = box_l;
        walk_k++;
        if (walk_k >= dir_y) begin
          begin_columns();
          return;
        end
      end
      pos_y = box_t + walk_k;
    end else if (walk_phase == dlsg_pkg::PH_SIDE) begin
      pos_y++;
      if (pos_y >= box_b) begin
        pos_y = col_top;
        walk_k++;
        if (walk_k >= ax) begin
          walk_phase = dlsg_pkg::PH_DONE;
          return;
        end
      end
      pos_x = (dir_x > 0) ? box_l + walk_k : box_r - 1 - walk_k;
    end
  endtask

  function automatic longint line_pixels();
    longint along, across, ax;
    ax = (dir_x < 0) ? -dir_x : dir_x;
    if (walk_phase == dlsg_pkg::PH_TOP) begin
      along = span(box_t + walk_k, box_b, dir_y);
      if (dir_x == 0) return along;
      across = (dir_x > 0) ? span(pos_x, box_r, dir_x) : span(box_l, pos_x + 1, ax);
    end else begin
      along = span(box_l + walk_k, box_r, ax);
      if (dir_y == 0) return along;
      across = span(pos_y, box_b, dir_y);
    end
    return (along < across) ? along : across;
  endfunction

  task automatic predict_line(input logic restart, output line_t exp);
    longint len;
    if (restart) restart_walk();
    exp = '0;
    if (walk_phase == dlsg_pkg::PH_DONE) return;
    len = line_pixels();
    if (len < 0) len = 0;
    if (len > (longint'(1) << CB) - 1) len = (longint'(1) << CB) - 1;
    exp.x = pos_x[CB-1:0];
    exp.y = pos_y[CB-1:0];
    exp.len = len[CB-1:0];
    exp.valid = 1'b1;
    move_on();
    exp.last = (walk_phase == dlsg_pkg::PH_DONE);
  endtask

  task automatic reset_model();
    reg_left = '0;
    reg_right = '0;
    reg_top = '0;
    reg_bottom = '0;
    reg_step_x = SB'(1);
    reg_step_y = '0;
    box_l = 0;
    box_r = 0;
    box_t = 0;
    box_b = 0;
    dir_x = 1;
    dir_y = 0;
    walk_phase = dlsg_pkg::PH_DONE;
    walk_k = 0;
    pos_x = 0;
    pos_y = 0;
    col_top = 0;
    line_q.delete();
  endtask

  always @(posedge clk) begin
    line_t exp, got;
    if (!rst_n) begin
      reset_model();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          dlsg_pkg::REG_BOX_LEFT:   reg_left   = cfg_wdata;
          dlsg_pkg::REG_BOX_RIGHT:  reg_right  = cfg_wdata;
          dlsg_pkg::REG_BOX_TOP:    reg_top    = cfg_wdata;
          dlsg_pkg::REG_BOX_BOTTOM: reg_bottom = cfg_wdata;
          dlsg_pkg::REG_STEP_X:     reg_step_x = cfg_wdata[SB-1:0];
          dlsg_pkg::REG_STEP_Y:     reg_step_y = cfg_wdata[SB-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_line(in_tdata[0], exp);
        line_q.push_back(exp);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[CB-1:0], out_tdata[2*CB-1:CB],
               out_tdata[3*CB-1:2*CB], out_tuser, out_tlast};
        if (line_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected line x=%0d y=%0d len=%0d valid=%b last=%b", $time,
                     $signed(got.x), $signed(got.y), got.len, got.valid, got.last);
        end else begin
          exp = line_q.pop_front();
          if (got.x !== exp.x || got.y !== exp.y || got.len !== exp.len ||
              got.valid !== exp.valid || got.last !== exp.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: line mismatch: expected x=%0d y=%0d len=%0d valid=%b last=%b",
                       $time, $signed(exp.x), $signed(exp.y), exp.len, exp.valid, exp.last,
                       ", got x=%0d y=%0d len=%0d valid=%b last=%b",
                       $signed(got.x), $signed(got.y), got.len, got.valid, got.last);
          end
        end
      end
    end
    lines_pending = line_q.size();
  end

endmodule

// ----- dv/directional_line_start_generator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Directional line start generator testbench
// Directed boxes, several at the coordinate limits, then random boxes and directions
// walked by restart/next item sequences with random stalls on both channels.
// ----------------------------------------------------------------------------
module directional_line_start_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CB = dlsg_pkg::COORD_BITS;
  localparam int SB = dlsg_pkg::STEP_BITS;
  localparam int AB = dlsg_pkg::CFG_ADDR_BITS;
  localparam int IB = dlsg_pkg::IN_TDATA_BITS;
  localparam int OB = dlsg_pkg::OUT_TDATA_BITS;
  localparam int SMAX = dlsg_pkg::STEP_MAX;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [AB-1:0] cfg_addr = '0;
  logic [CB-1:0] cfg_wdata = '0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [IB-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [OB-1:0] out_tdata;
  logic          out_tuser;
  logic          out_tlast;
  int            fail_count;
  int            lines_pending;

  int items_sent = 0;
  int tx_gap_pct = 20;
  int rx_stall_pct = 20;
  int rx_hold_req = 0;

  directional_line_start_generator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  line_start_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .lines_pending (lines_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  // number of lines a walk over this box gives
  function automatic int walk_lines(logic [CB-1:0] l, r, t, b,
                                    logic [SB-1:0] sx, sy);
    int vx, vy, w, h, ax;
    vx = $signed(sx);
    vy = $signed(sy);
    if (vx < -SMAX) vx = -SMAX;
    if (vy < -SMAX) vy = -SMAX;
    if (vy < 0) begin
      vx = -vx;
      vy = -vy;
    end
    w = $signed(r) - $signed(l);
    h = $signed(b) - $signed(t);
    if (w <= 0 || h <= 0 || (vx == 0 && vy == 0)) return 0;
    ax = (vx < 0) ? -vx : vx;
    return w * vy + ((vx != 0 && h > vy) ? ax * (h - vy) : 0);
  endfunction

  task automatic send_item(input logic restart);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IB-1){1'b0}}, restart};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (lines_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [AB-1:0] idx,
                           input logic [CB-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_walk(input logic [CB-1:0] l, r, t, b,
                          input logic [SB-1:0] sx, sy);
    write_reg(dlsg_pkg::REG_BOX_LEFT, l);
    write_reg(dlsg_pkg::REG_BOX_RIGHT, r);
    write_reg(dlsg_pkg::REG_BOX_TOP, t);
    write_reg(dlsg_pkg::REG_BOX_BOTTOM, b);
    write_reg(dlsg_pkg::REG_STEP_X, {{(CB-SB){sx[SB-1]}}, sx});
    write_reg(dlsg_pkg::REG_STEP_Y, {{(CB-SB){sy[SB-1]}}, sy});
    cfg_we <= 1'b0;
  endtask

  task automatic pick_walk(output logic [CB-1:0] l, r, t, b,
                           output logic [SB-1:0] sx, sy);
    int kind, w, h, lv, tv, v;
    kind = $urandom_range(99);
    w = $urandom_range(6, 1);
    h = $urandom_range(6, 1);
    lv = $urandom_range(65535 - w) - 32768;
    tv = $urandom_range(65535 - h) - 32768;
    v = $urandom_range(6) - 3;
    sx = v[SB-1:0];
    v = $urandom_range(6) - 3;
    sy = v[SB-1:0];
    if ($urandom_range(4) == 0) sx = SB'($urandom_range(31));
    if ($urandom_range(4) == 0) sy = SB'($urandom_range(31));
    if (kind < 15) begin
      // against the coordinate limits
      lv = $urandom_range(1) ? -32768 : 32767 - w;
      tv = $urandom_range(1) ? -32768 : 32767 - h;
    end else if (kind < 25) begin
      // empty box
      lv = ($urandom_range(3) == 0) ? 32767 : $urandom_range(65533) - 32766;
      tv = $urandom_range(65533) - 32766;
      if ($urandom_range(1)) w = -int'($urandom_range(2));
      else h = -int'($urandom_range(2));
    end else if (kind < 35) begin
      // full-width box, long lines
      lv = -32768;
      w = 65535;
      if ($urandom_range(1)) begin
        tv = -32768;
        h = 65535;
      end
    end else if (kind < 43) begin
      sx = '0;
      sy = '0;
    end
    l = lv[CB-1:0];
    r = CB'(lv + w);
    t = tv[CB-1:0];
    b = CB'(tv + h);
  endtask

  initial begin : rx_side
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        stall_left = idle_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [CB-1:0] l, r, t, b;
    logic [SB-1:0] sx, sy;
    int lines, cap, n, grp, first_item;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // never started, then restart on the empty reset box
    send_item(1'b0);
    send_item(1'b1);
    wait_drained();

    // direction (2,-1) flips to (-2,1): top row, then right columns
    set_walk(16'h8000, 16'h8003, 16'h7FFC, 16'h7FFF, 5'd2, 5'h1F);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    wait_drained();

    // new registers mid-walk: old walk runs out, exhausted, then restart
    set_walk(16'h7FFD, 16'h7FFF, 16'h8000, 16'h8001, 5'd0, 5'h10);
    repeat (4) send_item(1'b0);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    wait_drained();

    // zero direction
    set_walk(16'h0000, 16'h0004, 16'hFFFE, 16'h0001, 5'd0, 5'd0);
    send_item(1'b1);
    wait_drained();

    // horizontal only, saturated step, columns past the box
    set_walk(16'hFFFD, 16'h0000, 16'h0010, 16'h0011, 5'h10, 5'd0);
    send_item(1'b1);
    repeat (4) send_item(1'b0);

    grp = 0;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      wait_drained();
      pick_walk(l, r, t, b, sx, sy);
      set_walk(l, r, t, b, sx, sy);
      lines = walk_lines(l, r, t, b, sx, sy);
      tx_gap_pct = pick_pct();
      rx_stall_pct = pick_pct();
      if (grp == 2) begin
        // long receiver hold-off while items keep coming
        tx_gap_pct = 0;
        rx_hold_req = 300;
        repeat (20) send_item($urandom_range(7) == 0);
      end
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) send_item(1'b0);
        repeat ($urandom_range(3, 1)) begin
          send_item(1'b1);
          cap = $urandom_range(40, 8);
          n = (lines < cap) ? lines : cap;
          for (int j = 1; j < n; j++) send_item(1'b0);
          if ($urandom_range(2) == 0) repeat ($urandom_range(2, 1)) send_item(1'b0);
        end
      end else begin
        repeat ($urandom_range(30, 5)) send_item($urandom_range(3) == 0);
      end
      grp++;
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && lines_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
